FILE: sv/pmd_pkg.sv
// Package for the packed Morse decoder: symbol and event codes, the event
// beat type and the character lookup table. No dependencies.
package pmd_pkg;

  // Longest pending dot/dash pattern
  localparam int MAX_PATTERN_LEN = 6;
  localparam int PAT_W           = MAX_PATTERN_LEN;
  localparam int LEN_W           = $clog2(MAX_PATTERN_LEN + 1);

  localparam int NUM_CODES = 48;
  localparam int CODE_W    = 6;
  localparam logic [CODE_W-1:0] CODE_SPACE = 6'd48;

  // 2-bit symbols as packed in the input byte
  localparam logic [1:0] SYM_END   = 2'b00;
  localparam logic [1:0] SYM_DASH  = 2'b01;
  localparam logic [1:0] SYM_DOT   = 2'b10;
  localparam logic [1:0] SYM_SPACE = 2'b11;

  // Events passed from front to back; a space symbol becomes END then SPACE
  typedef enum logic [1:0] {
    EV_DOT,
    EV_DASH,
    EV_END,
    EV_SPACE
  } ev_op_t;

  typedef struct packed {
    ev_op_t op;
    logic   eob;   // final event of its input byte
  } ev_t;

  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] code;
  } lookup_t;

  // Pattern length and bits per character code (first symbol MSB, dash = 1)
  localparam logic [7:0] CODE_LEN [NUM_CODES] = '{
    8'd2, 8'd4, 8'd4, 8'd3, 8'd1, 8'd4, 8'd3, 8'd4, 8'd2, 8'd4, 8'd3, 8'd4,
    8'd2, 8'd2, 8'd3, 8'd4, 8'd4, 8'd3, 8'd3, 8'd1, 8'd3, 8'd4, 8'd3, 8'd4,
    8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4,
    8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5,
    8'd6, 8'd6, 8'd6, 8'd5, 8'd6, 8'd6, 8'd6, 8'd5
  };

  localparam logic [7:0] CODE_BITS [NUM_CODES] = '{
    8'h01, 8'h08, 8'h0A, 8'h04, 8'h00, 8'h02, 8'h06, 8'h00, 8'h00, 8'h07, 8'h05,
    8'h04, 8'h03, 8'h02, 8'h07, 8'h06, 8'h0D, 8'h02, 8'h00, 8'h01, 8'h01, 8'h01,
    8'h03, 8'h09, 8'h0B, 8'h0C, 8'h05, 8'h0E, 8'h03, 8'h0F,
    8'h1F, 8'h0F, 8'h07, 8'h03, 8'h01, 8'h00, 8'h10, 8'h18, 8'h1C, 8'h1E,
    8'h15, 8'h33, 8'h0C, 8'h06, 8'h38, 8'h12, 8'h1E, 8'h11
  };

  // Table match; the lowest matching code wins
  function automatic lookup_t pmd_lookup(input logic [LEN_W-1:0] len,
                                         input logic [PAT_W-1:0] bits);
    lookup_t r;
    r.hit  = 1'b0;
    r.code = '0;
    for (int i = NUM_CODES - 1; i >= 0; i--) begin
      if (CODE_LEN[i] == 8'(len) && CODE_BITS[i] == 8'(bits)) begin
        r.hit  = 1'b1;
        r.code = CODE_W'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: sv/packed_morse_decoder_core.sv
// Packed Morse decoder: each input byte carries four 2-bit symbols, MSB pair
// first (00 letter end, 01 dash, 10 dot, 11 letter end then space). The front
// end turns a byte into one event a cycle while the queue takes them, four per
// byte plus one for every space symbol; the back end, while its output buffer
// has room, updates the pattern and looks up one event a cycle and delivers at
// most one character beat a cycle. A decoded character is held until the next
// result or the end of its byte is seen, so every beat but the final one of a
// byte can leave as soon as the next result is decoded, while the final one,
// with last set, waits for the last symbol of its byte. Empty, unknown or
// overlong letters give no beat. Depends on pmd_pkg, pmd_front, pmd_evq and pmd_back.
module packed_morse_decoder_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 data_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pmd_pkg::CODE_W-1:0] char_code,
  output logic                       last
);
  import pmd_pkg::*;

  logic fe_valid, fe_ready;
  ev_t  fe_ev;
  logic q_valid, q_ready;
  ev_t  q_ev;

  pmd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .fe_valid  (fe_valid),
    .fe_ready  (fe_ready),
    .fe_ev     (fe_ev)
  );

  pmd_evq u_evq (
    .clk     (clk),
    .rst     (rst),
    .s_valid (fe_valid),
    .s_ready (fe_ready),
    .s_ev    (fe_ev),
    .m_valid (q_valid),
    .m_ready (q_ready),
    .m_ev    (q_ev)
  );

  pmd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ev_valid  (q_valid),
    .ev_ready  (q_ready),
    .ev        (q_ev),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_code (char_code),
    .last      (last)
  );

  // An accepted byte always yields an event beat on the next cycle
  a_byte_gives_event: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> fe_valid)
    else $error("front end idle after taking a byte");

  // A new byte is only taken as the final event of the previous one leaves
  a_byte_boundary: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !fe_valid || (fe_ready && fe_ev.eob))
    else $error("byte taken while events of the previous byte remain");

  // A stalled event beat holds
  a_event_holds: assert property (@(posedge clk) disable iff (rst)
    fe_valid && !fe_ready |=> fe_valid && $stable(fe_ev))
    else $error("front end event changed while stalled");

endmodule

FILE: sv/pmd_front.sv
// Front end of the packed Morse decoder: takes input bytes and splits them
// into event beats, one per cycle while fe_ready is high. Depends on pmd_pkg.
module pmd_front (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   data_byte,
  output logic         fe_valid,
  input  logic         fe_ready,
  output pmd_pkg::ev_t fe_ev
);
  import pmd_pkg::*;

  logic       busy;
  logic [1:0] sidx;
  logic       sp_phase;   // END of a space symbol sent, SPACE still due
  logic [7:0] byte_q;
  logic [1:0] sym;
  logic       split_space;

  // Current symbol, MSB pair first
  always_comb begin
    case (sidx)
      2'd0:    sym = byte_q[7:6];
      2'd1:    sym = byte_q[5:4];
      2'd2:    sym = byte_q[3:2];
      default: sym = byte_q[1:0];
    endcase
  end

  // Event for the current symbol
  always_comb begin
    split_space = (sym == SYM_SPACE) && !sp_phase;
    if (sp_phase) begin
      fe_ev.op = EV_SPACE;
    end else begin
      case (sym)
        SYM_DASH: fe_ev.op = EV_DASH;
        SYM_DOT:  fe_ev.op = EV_DOT;
        default:  fe_ev.op = EV_END;
      endcase
    end
    fe_ev.eob = (sidx == 2'd3) && !split_space;
  end

  assign fe_valid = busy;
  // Next byte is taken as the last event of this one leaves
  assign in_ready = !busy || (fe_ready && fe_ev.eob);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      sidx     <= 2'd0;
      sp_phase <= 1'b0;
    end else if (in_valid && in_ready) begin
      busy     <= 1'b1;
      sidx     <= 2'd0;
      sp_phase <= 1'b0;
    end else if (busy && fe_ready) begin
      if (fe_ev.eob) begin
        busy <= 1'b0;
      end else if (split_space) begin
        sp_phase <= 1'b1;
      end else begin
        sp_phase <= 1'b0;
        sidx     <= sidx + 2'd1;
      end
    end
  end

  // Byte holding register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= data_byte;
    end
  end

endmodule

FILE: sv/pmd_evq.sv
// Two-entry event queue between the front and back ends of the packed Morse
// decoder. Depends on pmd_pkg.
module pmd_evq (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_valid,
  output logic         s_ready,
  input  pmd_pkg::ev_t s_ev,
  output logic         m_valid,
  input  logic         m_ready,
  output pmd_pkg::ev_t m_ev
);
  import pmd_pkg::*;

  ev_t        q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign s_ready = (cnt != 2'd2);
  assign m_valid = (cnt != 2'd0);
  assign m_ev    = q[rp];
  assign push    = s_valid && s_ready;
  assign pop     = m_valid && m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= s_ev;
    end
  end

endmodule

FILE: sv/pmd_back.sv
// Back end of the packed Morse decoder: pattern state, character lookup,
// last-of-byte tagging and a two-entry output buffer. Depends on pmd_pkg.
module pmd_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       ev_valid,
  output logic                       ev_ready,
  input  pmd_pkg::ev_t               ev,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pmd_pkg::CODE_W-1:0] char_code,
  output logic                       last
);
  import pmd_pkg::*;

  // Pattern state
  logic [PAT_W-1:0]  pat_bits;
  logic [LEN_W-1:0]  pat_len;
  logic              pat_ovf;
  // Newest result, held back until it is known whether it ends the byte
  logic              held_v;
  logic [CODE_W-1:0] held_code;
  // Output buffer
  logic [CODE_W-1:0] ob_code [2];
  logic              ob_last [2];
  logic              ob_wp;
  logic              ob_rp;
  logic [1:0]        ob_cnt;

  lookup_t           lk;
  logic              hit;
  logic              new_v;
  logic [CODE_W-1:0] new_code;
  logic              p0_v, p0_last, p1_v;
  logic [CODE_W-1:0] p0_code;
  logic [1:0]        need;
  logic [1:0]        free;
  logic              pop;
  logic              accept;

  // Letter decode
  always_comb begin
    lk       = pmd_lookup(pat_len, pat_bits);
    hit      = lk.hit && !pat_ovf && (pat_len != '0);
    new_v    = ((ev.op == EV_END) && hit) || (ev.op == EV_SPACE);
    new_code = (ev.op == EV_SPACE) ? CODE_SPACE : lk.code;
  end

  // Beats to push for this event: held result first, then the new one at byte end
  always_comb begin
    p0_v    = 1'b0;
    p0_code = held_code;
    p0_last = 1'b0;
    p1_v    = 1'b0;
    if (new_v) begin
      if (held_v) begin
        p0_v = 1'b1;
        p1_v = ev.eob;
      end else if (ev.eob) begin
        p0_v    = 1'b1;
        p0_code = new_code;
        p0_last = 1'b1;
      end
    end else if (ev.eob && held_v) begin
      p0_v    = 1'b1;
      p0_last = 1'b1;
    end
    need = {1'b0, p0_v} + {1'b0, p1_v};
  end

  assign out_valid = (ob_cnt != 2'd0);
  assign char_code = ob_code[ob_rp];
  assign last      = ob_last[ob_rp];
  assign pop       = out_valid && out_ready;
  assign free      = 2'd2 - ob_cnt + {1'b0, pop};
  assign ev_ready  = (free >= need);
  assign accept    = ev_valid && ev_ready;

  // Control and pattern state
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_bits <= '0;
      pat_len  <= '0;
      pat_ovf  <= 1'b0;
      held_v   <= 1'b0;
      ob_wp    <= 1'b0;
      ob_rp    <= 1'b0;
      ob_cnt   <= 2'd0;
    end else begin
      if (pop) ob_rp <= ~ob_rp;
      if (accept) begin
        ob_wp  <= ob_wp ^ need[0];
        ob_cnt <= ob_cnt + need - {1'b0, pop};
        if (ev.eob) begin
          held_v <= 1'b0;
        end else if (new_v) begin
          held_v <= 1'b1;
        end
        case (ev.op)
          EV_DOT, EV_DASH: begin
            if (pat_len >= LEN_W'(MAX_PATTERN_LEN)) begin
              pat_ovf <= 1'b1;
            end else begin
              pat_bits <= {pat_bits[PAT_W-2:0], ev.op == EV_DASH};
              pat_len  <= pat_len + LEN_W'(1);
            end
          end
          EV_END: begin
            pat_bits <= '0;
            pat_len  <= '0;
            pat_ovf  <= 1'b0;
          end
          default: ;
        endcase
      end else begin
        ob_cnt <= ob_cnt - {1'b0, pop};
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      if (new_v && !ev.eob) begin
        held_code <= new_code;
      end
      if (p0_v) begin
        ob_code[ob_wp] <= p0_code;
        ob_last[ob_wp] <= p0_last;
      end
      if (p1_v) begin
        ob_code[~ob_wp] <= new_code;
        ob_last[~ob_wp] <= 1'b1;
      end
    end
  end

endmodule

FILE: sim/tb_packed_morse_decoder_core.sv
// Self-checking testbench for packed_morse_decoder_core: directed and random
// byte streams against an in-bench decoder model, with random idling on both
// channels. Depends on pmd_pkg and the decoder RTL.
module tb_packed_morse_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pmd_pkg::*;

  localparam int PATTERN_MAX  = 6;
  localparam int CHAR_COUNT   = 48;
  localparam int TARGET_BYTES = 460;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_MAX   = 10;

  // Dot/dash patterns per character code, first symbol in the MSB, dash = 1
  localparam logic [2:0] MORSE_LEN [CHAR_COUNT] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4,
    3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
    3'd6, 3'd6, 3'd6, 3'd5, 3'd6, 3'd6, 3'd6, 3'd5
  };
  localparam logic [5:0] MORSE_BITS [CHAR_COUNT] = '{
    6'h01, 6'h08, 6'h0A, 6'h04, 6'h00, 6'h02, 6'h06, 6'h00, 6'h00, 6'h07,
    6'h05, 6'h04, 6'h03, 6'h02, 6'h07, 6'h06, 6'h0D, 6'h02, 6'h00, 6'h01,
    6'h01, 6'h01, 6'h03, 6'h09, 6'h0B, 6'h0C, 6'h05, 6'h0E, 6'h03, 6'h0F,
    6'h1F, 6'h0F, 6'h07, 6'h03, 6'h01, 6'h00, 6'h10, 6'h18, 6'h1C, 6'h1E,
    6'h15, 6'h33, 6'h0C, 6'h06, 6'h38, 6'h12, 6'h1E, 6'h11
  };

  // Hand-picked bytes: empty letters, spaces, letters split over bytes,
  // a full six-symbol letter, unknown and overlong patterns
  localparam logic [7:0] DIRECTED_BYTES [25] = '{
    8'h00, 8'hFF, 8'h80, 8'h40, 8'h9C, 8'h55, 8'h00, 8'h99, 8'h90, 8'hAA,
    8'hA0, 8'hAA, 8'hA4, 8'h80, 8'h5F, 8'hAA, 8'hAA, 8'h00, 8'h80, 8'h0F,
    8'h7F, 8'h96, 8'hC0, 8'hA5, 8'h00
  };

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } char_beat_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [7:0]        data_byte = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CODE_W-1:0] char_code;
  logic              last;

  logic [7:0] pending_bytes [$];
  char_beat_t expected_chars [$];
  char_beat_t oldest_char;

  // Decoder model state
  logic [5:0] pat_bits = '0;
  int         pat_len  = 0;
  logic       pat_over = 1'b0;

  // Symbol packer for stimulus
  logic [7:0] sym_buf   = '0;
  int         sym_count = 0;

  int   send_gap_pct   = 0;
  int   sink_stall_pct = 0;
  int   bytes_accepted = 0;
  int   total_bytes    = 0;
  int   mismatches     = 0;
  int   cycle_count    = 0;
  logic in_taken       = 1'b0;

  packed_morse_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_code (char_code),
    .last      (last)
  );

  always #1 clk = ~clk;

  task automatic note_failure(input string what);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("%s", what);
  endtask

  // Model: run one byte through the pattern state, queue its characters
  task automatic decode_byte(input logic [7:0] b);
    char_beat_t produced [$];
    char_beat_t beat;
    logic [1:0] sym;
    int         hit;
    for (int s = 0; s < 4; s++) begin
      sym = b[7-2*s -: 2];
      if (sym == SYM_DASH || sym == SYM_DOT) begin
        if (pat_len >= PATTERN_MAX) begin
          pat_over = 1'b1;
        end else begin
          pat_bits = {pat_bits[4:0], sym == SYM_DASH};
          pat_len++;
        end
      end else begin
        // letter end: lowest matching code wins
        if (!pat_over && pat_len != 0) begin
          hit = -1;
          for (int i = 0; i < CHAR_COUNT; i++) begin
            if (hit < 0 && int'(MORSE_LEN[i]) == pat_len && MORSE_BITS[i] == pat_bits)
              hit = i;
          end
          if (hit >= 0) begin
            beat.code = CODE_W'(hit);
            beat.last = 1'b0;
            produced = {produced, beat};
          end
        end
        pat_bits = '0;
        pat_len  = 0;
        pat_over = 1'b0;
        if (sym == SYM_SPACE) begin
          beat.code = CODE_SPACE;
          beat.last = 1'b0;
          produced = {produced, beat};
        end
      end
    end
    if (produced.size() > 0) produced[produced.size()-1].last = 1'b1;
    expected_chars = {expected_chars, produced};
  endtask

  task automatic push_symbol(input logic [1:0] sym);
    sym_buf = {sym_buf[5:0], sym};
    sym_count++;
    if (sym_count == 4) begin
      pending_bytes = {pending_bytes, sym_buf};
      sym_count = 0;
    end
  endtask

  task automatic push_letter(input int code, input logic [1:0] term);
    for (int i = int'(MORSE_LEN[code]) - 1; i >= 0; i--)
      push_symbol(MORSE_BITS[code][i] ? SYM_DASH : SYM_DOT);
    push_symbol(term);
  endtask

  function automatic logic [1:0] any_mark();
    return ($urandom_range(1) == 1) ? SYM_DASH : SYM_DOT;
  endfunction

  // Input side: note accepted beats and predict; output side: check
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        bytes_accepted++;
        decode_byte(data_byte);
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          note_failure($sformatf("unexpected beat: code %0d last %0b", char_code, last));
        end else begin
          oldest_char = expected_chars.pop_front();
          if (char_code !== oldest_char.code || last !== oldest_char.last)
            note_failure($sformatf("beat mismatch: expected code %0d last %0b, got code %0d last %0b",
                                   oldest_char.code, oldest_char.last, char_code, last));
        end
      end
    end
  end

  // Driver: new beat once the previous one is taken, random gaps and stalls
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      if (pending_bytes.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        data_byte <= pending_bytes.pop_front();
        in_valid  <= 1'b1;
      end else begin
        in_valid  <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int pick;
    int n;

    foreach (DIRECTED_BYTES[i]) pending_bytes = {pending_bytes, DIRECTED_BYTES[i]};

    // Random part: mostly well-formed letters, some broken patterns and noise
    while (pending_bytes.size() < TARGET_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        push_letter($urandom_range(CHAR_COUNT - 1),
                    ($urandom_range(4) == 0) ? SYM_SPACE : SYM_END);
        if ($urandom_range(9) == 0) push_symbol(SYM_END);
      end else if (pick < 80) begin
        n = $urandom_range(PATTERN_MAX + 4, PATTERN_MAX + 1);
        repeat (n) push_symbol(any_mark());
        push_symbol(SYM_END);
      end else if (pick < 90) begin
        n = $urandom_range(PATTERN_MAX, 1);
        repeat (n) push_symbol(any_mark());
        push_symbol(($urandom_range(3) == 0) ? SYM_SPACE : SYM_END);
      end else begin
        repeat (4) push_symbol(2'($urandom_range(3)));
      end
    end
    while (sym_count != 0) push_symbol(SYM_END);
    total_bytes = pending_bytes.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Idle phases: none, sender, receiver, both, then none again
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin
          send_gap_pct   = 47;
          sink_stall_pct = 0;
        end
        2: begin
          send_gap_pct   = 0;
          sink_stall_pct = 47;
        end
        3: begin
          send_gap_pct   = 31;
          sink_stall_pct = 31;
        end
        default: begin
          send_gap_pct   = 0;
          sink_stall_pct = 0;
        end
      endcase
      while (bytes_accepted < ((ph + 1) * total_bytes) / 5) @(posedge clk);
    end

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0)
      note_failure($sformatf("%0d beats never arrived", expected_chars.size()));

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/pmd_pkg.sv
sv/pmd_front.sv
sv/pmd_evq.sv
sv/pmd_back.sv
sv/packed_morse_decoder_core.sv
sim/tb_packed_morse_decoder_core.sv
